/* rtl/oldq_pkg.sv */
package oldq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int POS_W      = 5;
  localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef logic [CMD_W-1:0]      cmd_code_t;
  typedef logic [STATUS_W-1:0]   status_code_t;
  typedef logic [DATA_WIDTH-1:0] elem_t;

  localparam cmd_code_t CMD_APPEND    = 3'd0;
  localparam cmd_code_t CMD_PUSH_HEAD = 3'd1;
  localparam cmd_code_t CMD_INSERT_AT = 3'd2;
  localparam cmd_code_t CMD_POP_HEAD  = 3'd3;
  localparam cmd_code_t CMD_POP_TAIL  = 3'd4;
  localparam cmd_code_t CMD_REMOVE_AT = 3'd5;

  localparam status_code_t ST_OK    = 2'd0;
  localparam status_code_t ST_FULL  = 2'd1;
  localparam status_code_t ST_EMPTY = 2'd2;
  localparam status_code_t ST_RANGE = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // apply the held item and load the result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic held_valid;  // an item sits in the input register
  } dp_status_t;

endpackage

/* rtl/oldq_ctrl.sv */
module oldq_ctrl import oldq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_status_t dp_status,
  output dp_cmd_t    dp_cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    dp_cmd.load = 1'b0;
    dp_cmd.exec = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait for the result register to drain before applying the item
        if (slot_free && dp_status.held_valid) begin
          dp_cmd.exec = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.exec) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/oldq_datapath.sv */
module oldq_datapath import oldq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               dp_cmd,
  output dp_status_t            dp_status,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cmd_code_t        cmd_r;
  logic [POS_W-1:0] pos_r;
  elem_t            val_r;
  logic             held_r, held_nxt;

  elem_t            cell_r   [DEPTH];
  elem_t            cell_nxt [DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;

  elem_t            res_val_r;
  status_code_t     res_st_r;
  logic [CNT_W-1:0] res_cnt_r;

  logic             full, empty;
  logic [CMP_W-1:0] pos_e, cnt_e, pos_m1;
  logic             do_ins, do_rem;
  logic [IDX_W-1:0] ins_idx, rem_idx;
  status_code_t     st;
  elem_t            rem_val;

  assign dp_status.held_valid = held_r;

  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);
  assign pos_e  = CMP_W'(pos_r);
  assign cnt_e  = CMP_W'(count_r);
  assign pos_m1 = pos_e - CMP_W'(1);

  always_comb begin
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    ins_idx = '0;
    rem_idx = '0;
    st      = ST_OK;
    unique case (cmd_r)
      CMD_APPEND, CMD_PUSH_HEAD, CMD_INSERT_AT: begin
        priority if (full) begin
          st = ST_FULL;
        end else if (cmd_r == CMD_APPEND) begin
          do_ins  = 1'b1;
          ins_idx = count_r[IDX_W-1:0];
        end else if (cmd_r == CMD_PUSH_HEAD) begin
          do_ins = 1'b1;
        end else if (pos_e == '0 || pos_e > cnt_e + CMP_W'(1)) begin
          st = ST_RANGE;
        end else begin
          do_ins  = 1'b1;
          ins_idx = pos_m1[IDX_W-1:0];
        end
      end
      CMD_POP_HEAD, CMD_POP_TAIL, CMD_REMOVE_AT: begin
        priority if (empty) begin
          st = ST_EMPTY;
        end else if (cmd_r == CMD_POP_HEAD) begin
          do_rem = 1'b1;
        end else if (cmd_r == CMD_POP_TAIL) begin
          do_rem  = 1'b1;
          rem_idx = IDX_W'(count_r - CNT_W'(1));
        end else if (pos_e == '0 || pos_e > cnt_e) begin
          st = ST_RANGE;
        end else begin
          do_rem  = 1'b1;
          rem_idx = pos_m1[IDX_W-1:0];
        end
      end
      default: ;  // unused codes leave the list alone
    endcase
  end

  assign rem_val = do_rem ? cell_r[rem_idx] : '0;

  // cells from the insert or remove point on shift in parallel; cells past the tail
  // may pick up stale data, they are never read
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
      if (do_ins) begin
        if (IDX_W'(i) == ins_idx) cell_nxt[i] = val_r;
        else if (IDX_W'(i) > ins_idx && i > 0) cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
      end else if (do_rem) begin
        if (IDX_W'(i) >= rem_idx && i < DEPTH - 1)
          cell_nxt[i] = cell_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) count_nxt = count_r + CNT_W'(1);
    else if (do_rem) count_nxt = count_r - CNT_W'(1);
  end

  always_comb begin
    held_nxt = held_r;
    if (dp_cmd.load) held_nxt = 1'b1;
    else if (dp_cmd.exec) held_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      held_r  <= 1'b0;
    end else begin
      held_r <= held_nxt;
      if (dp_cmd.exec) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r <= in_tdata[CMD_W-1:0];
      pos_r <= in_tdata[CMD_W +: POS_W];
      val_r <= in_tdata[CMD_W + POS_W +: DATA_WIDTH];
    end
    if (dp_cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) cell_r[i] <= cell_nxt[i];
      res_val_r <= rem_val;
      res_st_r  <= st;
      res_cnt_r <= count_nxt;
    end
  end

  assign out_tdata = {{(OUT_DATA_W - DATA_WIDTH - STATUS_W - CNT_W){1'b0}},
                      res_cnt_r, res_st_r, res_val_r};

endmodule

/* rtl/ordered_list_deque_engine.sv */
// Channel | Direction | Ports                     | Item
// in      | sink      | in_tvalid/tready/tdata    | one list command
// out     | source    | out_tvalid/tready/tdata   | one result per command
//
// Each command is first captured, then applied to the register cells; the cells
// from the insert or remove point on shift toward a neighbor together.
// The apply step waits while the result register still holds an untaken item.
// Reset (rst_n low, synchronous) empties the list; cell contents are not cleared.
// in_tready is low from capture until the command is applied.
module ordered_list_deque_engine import oldq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [2:0] cmd, [7:3] position, [39:8] value
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] removed_value, [33:32] status, [38:34] element_count, [39] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  oldq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_status  (dp_status),
    .dp_cmd     (dp_cmd)
  );

  oldq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

/* rtl/oldq_checker.sv */
module oldq_checker import oldq_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [CNT_W-1:0] res_cnt;
  status_code_t     res_st;

  assign res_cnt = out_tdata[DATA_WIDTH + STATUS_W +: CNT_W];
  assign res_st  = out_tdata[DATA_WIDTH +: STATUS_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken before the first was applied");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_cnt <= CNT_W'(DEPTH))
    else $error("element count beyond depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_st == ST_FULL |-> res_cnt == CNT_W'(DEPTH))
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_st == ST_EMPTY |-> res_cnt == '0 &&
      out_tdata[DATA_WIDTH-1:0] == '0)
    else $error("empty status with elements or a removed value");

endmodule

bind ordered_list_deque_engine oldq_checker u_oldq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
